/* design/dfas_pkg.sv */
// Shared constants and types for the dark-frame average and subtract block.
package dfas_pkg;

   localparam int PIXEL_COUNT  = 65536;
   localparam int ADDR_BITS    = $clog2(PIXEL_COUNT);
   localparam int SUM_BITS     = 24;
   localparam int FRAMES_BITS  = 16;
   localparam int RAW_BITS     = 8;
   localparam int VALUE_BITS   = 17;
   localparam int QUO_BITS     = 16;

   localparam logic [SUM_BITS-1:0]    SUM_MAX       = {SUM_BITS{1'b1}};
   localparam logic [QUO_BITS-1:0]    DARK_MAX      = 16'hFF00;
   localparam logic [FRAMES_BITS-1:0] FRAMES_RESET  = 16'd1000;
   localparam logic [ADDR_BITS-1:0]   ADDR_LAST     = ADDR_BITS'(PIXEL_COUNT - 1);

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_ACCUM   = 2'd1,
      OP_CORRECT = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   // Pixel address folded onto the store depth.
   function automatic logic [ADDR_BITS-1:0] to_index(input logic [15:0] addr);
      logic [ADDR_BITS+15:0] wide;
      wide = {{ADDR_BITS{1'b0}}, addr};
      return wide[ADDR_BITS-1:0];
   endfunction

endpackage

/* design/dark_frame_average_and_subtract.sv */
// Dark-frame average and subtract: per-pixel dark sum store, accumulate and correct.
// From accept to rsp_valid: unused opcode goes to output load; accumulate, uncalibrated
// and clamped correct do one store read; dividing correct: read, 16 restoring-divide steps,
// subtract, output load; clear: zero sweep of all PIXEL_COUNT entries, req_ready low.
// Throughput: one item at a time; next beat can be taken in the same cycle that rsp_valid rises.
// Reset: synchronous, active high; runs the same zero sweep of the store, frames_to_average = 1000.
module dark_frame_average_and_subtract (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  dfas_pkg::opcode_type                    req_opcode,
   input  logic [15:0]                             req_pixel_address,
   input  logic [dfas_pkg::RAW_BITS-1:0]           req_pixel_value,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dfas_pkg::VALUE_BITS-1:0]  rsp_corrected_value,
   output logic                                    rsp_status,
   // configuration
   input  logic                                    csr_write_enable,
   input  logic [dfas_pkg::FRAMES_BITS-1:0]        csr_write_data
);
   import dfas_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,   // sweeping zeros through the store
      S_IDLE,    // ready for a beat
      S_READ,    // store data for addr_ff available
      S_DIV,     // restoring divider, one quotient bit per cycle
      S_FIN,     // clamp average and subtract
      S_OUT      // waiting for output register space
   } state_type;

   // Dark sum store, registered synchronous read.
   logic [SUM_BITS-1:0] dark_sums_mem [PIXEL_COUNT];
   logic [SUM_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0] mem_raddr;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [SUM_BITS-1:0]  mem_wdata;
   logic                 mem_we;

   state_type                     state_ff, state_in;
   logic [ADDR_BITS-1:0]          clear_addr_ff, clear_addr_in;
   logic                          clear_reply_ff, clear_reply_in;
   logic                          dark_valid_ff, dark_valid_in;
   logic [FRAMES_BITS-1:0]        frames_ff, frames_in;
   opcode_type                    op_ff, op_in;
   logic [ADDR_BITS-1:0]          addr_ff, addr_in;
   logic [RAW_BITS-1:0]           raw_ff, raw_in;
   logic [QUO_BITS-1:0]           rem_ff, rem_in;
   logic [QUO_BITS-1:0]           quo_ff, quo_in;
   logic [3:0]                    count_ff, count_in;
   logic signed [VALUE_BITS-1:0]  res_value_ff, res_value_in;
   logic                          res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic                          rsp_status_ff, rsp_status_in;

   logic [FRAMES_BITS-1:0] divisor;
   logic [SUM_BITS:0]      sum_wide;
   logic [SUM_BITS-1:0]    sum_sat;
   logic [QUO_BITS+1:0]    div_trial;
   logic [QUO_BITS-1:0]    avg;
   logic [VALUE_BITS-1:0]  raw_scaled;

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_value = rsp_value_ff;
   assign rsp_status          = rsp_status_ff;

   // A zero divisor acts as one.
   assign divisor = (frames_ff == '0) ? FRAMES_BITS'(1) : frames_ff;

   // Read address: new beat's address while idle, else the held one.
   assign mem_raddr = (state_ff == S_IDLE) ? to_index(req_pixel_address) : addr_ff;

   // Saturating accumulate.
   assign sum_wide = {1'b0, rd_data_ff} + {{(SUM_BITS-RAW_BITS+1){1'b0}}, raw_ff};
   assign sum_sat  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

   // Divider step: shift next dividend bit into the remainder, try subtract.
   assign div_trial = {1'b0, rem_ff, quo_ff[QUO_BITS-1]} - {2'b00, divisor};

   assign avg        = (quo_ff > DARK_MAX) ? DARK_MAX : quo_ff;
   assign raw_scaled = {1'b0, raw_ff, 8'h00};

   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      clear_reply_in = clear_reply_ff;
      dark_valid_in  = dark_valid_ff;
      frames_in      = csr_write_enable ? csr_write_data : frames_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      raw_in         = raw_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      count_in       = count_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = clear_addr_ff;
      mem_wdata      = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we        = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_LAST) begin
               clear_reply_in = 1'b0;
               state_in       = clear_reply_ff ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_opcode;
               addr_in       = to_index(req_pixel_address);
               raw_in        = req_pixel_value;
               res_value_in  = '0;
               res_status_in = 1'b0;
               case (req_opcode)
                  OP_CLEAR: begin
                     dark_valid_in  = 1'b0;
                     clear_addr_in  = '0;
                     clear_reply_in = 1'b1;
                     state_in       = S_CLEAR;
                  end
                  OP_ACCUM:   state_in = S_READ;
                  OP_CORRECT: state_in = S_READ;
                  default:    state_in = S_OUT;
               endcase
            end
         end
         S_READ: begin
            case (op_ff)
               OP_ACCUM: begin
                  mem_we        = 1'b1;
                  mem_waddr     = addr_ff;
                  mem_wdata     = sum_sat;
                  dark_valid_in = 1'b1;
                  state_in      = S_OUT;
               end
               OP_CORRECT: begin
                  if (!dark_valid_ff) begin
                     res_status_in = 1'b1;
                     state_in      = S_OUT;
                  end else if (rd_data_ff[SUM_BITS-1:8] >= divisor) begin
                     // quotient reaches 2^16: average clamps to full scale
                     res_value_in = raw_scaled - {1'b0, DARK_MAX};
                     state_in     = S_OUT;
                  end else begin
                     // dividend = sum * 256; upper 16 bits are below the divisor
                     rem_in   = rd_data_ff[SUM_BITS-1:8];
                     quo_in   = {rd_data_ff[7:0], 8'h00};
                     count_in = '0;
                     state_in = S_DIV;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_DIV: begin
            if (!div_trial[QUO_BITS+1]) begin
               rem_in = div_trial[QUO_BITS-1:0];
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[QUO_BITS-2:0], quo_ff[QUO_BITS-1]};
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == 4'd15) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_value_in = raw_scaled - {1'b0, avg};
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_addr_ff  <= '0;
         clear_reply_ff <= 1'b0;
         dark_valid_ff  <= 1'b0;
         frames_ff      <= FRAMES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         clear_reply_ff <= clear_reply_in;
         dark_valid_ff  <= dark_valid_in;
         frames_ff      <= frames_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      raw_ff        <= raw_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      count_ff      <= count_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dark_sums_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= dark_sums_mem[mem_raddr];
   end

endmodule
